/* rtl/chained_hash_map_engine_assert.svh */
// Assertion macros shared by the checker of the chained hash map engine.
`ifndef CHAINED_HASH_MAP_ENGINE_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHME_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chme assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chme assertion failed");

// Next-cycle implication that also holds through reset.
`define CHME_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("chme reset assertion failed");

`endif

/* rtl/chme_pkg.sv */
// Types, codes and hash helpers of the chained hash map engine.
package chme_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_GET    = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_value;
    logic [10:0] item_total;
  } out_item_t;

  localparam logic [31:0] MIX_XOR = 32'd61;
  localparam logic [31:0] MIX_MUL = 32'h27d4eb2d;
  localparam int          MIX_SH_HI = 16;
  localparam int          MIX_SH_OUT = 15;

  // Mixing steps that come before the multiply.
  function automatic logic [31:0] mix_pre(logic [31:0] k);
    logic [31:0] x;
    x = (k ^ MIX_XOR) ^ (k >> MIX_SH_HI);
    x = x + (x << 3);
    return x ^ (x >> 4);
  endfunction

  // Final fold after the multiply.
  function automatic logic [31:0] mix_post(logic [31:0] p);
    return p ^ (p >> MIX_SH_OUT);
  endfunction

endpackage

/* rtl/chained_hash_map_engine.sv */
// The front end hashes each command (mix, multiply, fold, and a reciprocal divide when
// BUCKETS is not a power of two) and queues it; the back end then reads the head, walks
// the chain through the entry memories, finishes and registers the result. It takes the next
// queued command only when through with the last; inserts that allocate also pass a link state.
// Reset is synchronous and active low; all buckets read as empty at once, no sweep.
// The receiver cannot stall; each result is shown for exactly one cycle.
module chained_hash_map_engine #(
  parameter int BUCKETS = 32,
  parameter int ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  chme_pkg::in_item_t  in_item,
  output logic                out_valid,
  output chme_pkg::out_item_t out_result
);

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = $bits(chme_pkg::in_item_t) + BW;

  logic                q_push, q_full, q_pop, q_empty;
  chme_pkg::in_item_t  f_item, b_item;
  logic [BW-1:0]       f_bucket, b_bucket;
  logic [QW-1:0]       q_out;

  chme_front #(.BUCKETS(BUCKETS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .q_full(q_full), .q_push(q_push), .q_item(f_item), .q_bucket(f_bucket)
  );

  chme_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data({f_item, f_bucket}),
    .full(q_full), .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  assign b_item   = q_out[QW-1:BW];
  assign b_bucket = q_out[BW-1:0];

  chme_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_item(b_item), .q_bucket(b_bucket),
    .q_pop(q_pop), .out_valid(out_valid), .out_result(out_result)
  );

endmodule

/* rtl/chme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module chme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/chme_front.sv */
// Front end: accepts commands, hashes the key and picks the bucket.
module chme_front #(
  parameter int BUCKETS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  chme_pkg::in_item_t         in_item,
  input  logic                       q_full,
  output logic                       q_push,
  output chme_pkg::in_item_t         q_item,
  output logic [$clog2(BUCKETS)-1:0] q_bucket
);

  localparam int BW = $clog2(BUCKETS);
  localparam bit IS_POW2 = (BUCKETS == (1 << BW));
  // Rounded-up reciprocal that gives the exact quotient of any 32-bit hash.
  localparam logic [32:0] RECIP =
    33'(((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_MOD  = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t            state_r, state_nxt;
  chme_pkg::in_item_t item_r;
  logic [31:0]        x_r, prod_r, h_r, q_r;
  logic [BW-1:0]      rem_r;
  logic               step_r;
  logic [31:0]        h_c;
  logic [64:0]        qprod;

  assign busy     = (state_r != F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_item   = item_r;
  assign q_bucket = rem_r;
  assign h_c      = chme_pkg::mix_post(prod_r);
  assign qprod    = {33'd0, h_r} * {32'd0, RECIP};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (start) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_MOD;
      F_MOD:  state_nxt = IS_POW2 ? F_PUSH : F_DIV;
      F_DIV:  if (step_r) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Remainder by the bucket count: a mask for powers of two, else a reciprocal
  // multiply for the quotient and a multiply-subtract for the remainder.
  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          item_r <= in_item;
          x_r    <= chme_pkg::mix_pre(in_item.key);
        end
      end
      F_MUL: prod_r <= x_r * chme_pkg::MIX_MUL;
      F_MOD: begin
        h_r    <= h_c;
        step_r <= 1'b0;
        rem_r  <= IS_POW2 ? h_c[BW-1:0] : '0;
      end
      F_DIV: begin
        step_r <= 1'b1;
        if (!step_r) begin
          q_r <= 32'(qprod >> (32 + BW));
        end else begin
          rem_r <= BW'(h_r - q_r * 32'(BUCKETS));
        end
      end
      F_PUSH: ;
      default: ;
    endcase
  end

endmodule

/* rtl/chme_queue.sv */
// Two-entry queue between the front end and the table walker.
module chme_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

/* rtl/chme_back.sv */
// Back end: walks the bucket chain and carries out insert, erase and get.
module chme_back #(
  parameter int BUCKETS = 32,
  parameter int ENTRIES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  chme_pkg::in_item_t         q_item,
  input  logic [$clog2(BUCKETS)-1:0] q_bucket,
  output logic                       q_pop,
  output logic                       out_valid,
  output chme_pkg::out_item_t        out_result
);

  localparam int BW = $clog2(BUCKETS);
  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NULL_L = LW'(ENTRIES);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_HEAD = 5'b00010,
    B_WALK = 5'b00100,
    B_FIN  = 5'b01000,
    B_LINK = 5'b10000
  } bstate_t;

  bstate_t                state_r, state_nxt;
  chme_pkg::in_item_t     item_r;
  logic [BW-1:0]          bkt_r;
  logic [LW-1:0]          cur_r, prev_r, hit_link_r;
  logic                   hit_r;
  logic [31:0]            found_r;
  logic [IW-1:0]          free_top_r, alloc_r;
  logic [BUCKETS-1:0]     head_valid_r;
  logic [LW-1:0]          free_depth_r, fresh_r, count_r;
  logic                   out_valid_r;
  chme_pkg::out_item_t    out_r;

  // Memory ports.
  logic [LW-1:0]          head_rd, link_rd, link_wdata, head_wdata;
  logic [63:0]            kv_rd;
  logic [IW-1:0]          free_rd, ent_raddr, link_waddr;
  logic                   head_we, kv_we, link_we, free_we;

  // Resolution of the finishing cycle.
  logic [LW-1:0]          head_now, free_depth_nxt, fresh_nxt, count_nxt;
  logic [IW-1:0]          alloc_e;
  logic                   do_link;
  chme_pkg::status_t      status_c;

  assign head_now  = head_valid_r[bkt_r] ? head_rd : NULL_L;
  assign ent_raddr = (state_r == B_HEAD) ? IW'(head_now) : IW'(link_rd);
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_result = out_r;

  chme_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(bkt_r), .wdata(head_wdata),
    .raddr(q_bucket), .rdata(head_rd)
  );

  chme_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_kv_ram (
    .clk(clk), .we(kv_we), .waddr(alloc_e), .wdata({item_r.key, item_r.value}),
    .raddr(ent_raddr), .rdata(kv_rd)
  );

  chme_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(ent_raddr), .rdata(link_rd)
  );

  chme_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(IW'(free_depth_r)), .wdata(IW'(cur_r)),
    .raddr(IW'(free_depth_r - LW'(1))), .rdata(free_rd)
  );

  always_comb begin
    status_c       = chme_pkg::ST_OK;
    free_depth_nxt = free_depth_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    alloc_e        = free_top_r;
    do_link        = 1'b0;
    kv_we          = 1'b0;
    link_we        = 1'b0;
    link_waddr     = alloc_e;
    link_wdata     = NULL_L;
    head_we        = 1'b0;
    head_wdata     = hit_link_r;
    free_we        = 1'b0;
    if (state_r == B_FIN) begin
      unique case (item_r.op)
        chme_pkg::OP_INSERT: begin
          if (hit_r) begin
            status_c = chme_pkg::ST_DUP;
          end else if (free_depth_r != '0) begin
            alloc_e        = free_top_r;
            free_depth_nxt = free_depth_r - LW'(1);
            do_link        = 1'b1;
          end else if (fresh_r < NULL_L) begin
            alloc_e   = IW'(fresh_r);
            fresh_nxt = fresh_r + LW'(1);
            do_link   = 1'b1;
          end else begin
            status_c = chme_pkg::ST_FULL;
          end
          if (do_link) begin
            kv_we      = 1'b1;
            link_we    = 1'b1;
            link_waddr = alloc_e;
            link_wdata = NULL_L;
            count_nxt  = count_r + LW'(1);
          end
        end
        chme_pkg::OP_ERASE: begin
          if (!hit_r) begin
            status_c = chme_pkg::ST_MISSING;
          end else begin
            if (prev_r != NULL_L) begin
              link_we    = 1'b1;
              link_waddr = IW'(prev_r);
              link_wdata = hit_link_r;
            end else begin
              head_we    = 1'b1;
              head_wdata = hit_link_r;
            end
            if (free_depth_r < NULL_L) begin
              free_we        = 1'b1;
              free_depth_nxt = free_depth_r + LW'(1);
            end
            if (count_r != '0) count_nxt = count_r - LW'(1);
          end
        end
        chme_pkg::OP_GET: begin
          if (!hit_r) status_c = chme_pkg::ST_MISSING;
        end
        chme_pkg::OP_NOP: ;
        default: ;
      endcase
    end else if (state_r == B_LINK) begin
      // Hook the new entry onto the chain tail, or make it the head.
      alloc_e = alloc_r;
      if (prev_r != NULL_L) begin
        link_we    = 1'b1;
        link_waddr = IW'(prev_r);
        link_wdata = LW'(alloc_r);
      end else begin
        head_we    = 1'b1;
        head_wdata = LW'(alloc_r);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_HEAD;
      B_HEAD: state_nxt = (head_now >= NULL_L) ? B_FIN : B_WALK;
      B_WALK: begin
        if (kv_rd[63:32] == item_r.key || link_rd >= NULL_L) state_nxt = B_FIN;
      end
      B_FIN:  state_nxt = do_link ? B_LINK : B_IDLE;
      B_LINK: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      head_valid_r <= '0;
      free_depth_r <= '0;
      fresh_r      <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_depth_r <= free_depth_nxt;
      fresh_r      <= fresh_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= (state_r == B_FIN);
      if (head_we) head_valid_r[bkt_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        item_r <= q_item;
        bkt_r  <= q_bucket;
      end
      B_HEAD: begin
        cur_r      <= head_now;
        prev_r     <= NULL_L;
        hit_r      <= 1'b0;
        found_r    <= '0;
        free_top_r <= free_rd;
      end
      B_WALK: begin
        if (kv_rd[63:32] == item_r.key) begin
          hit_r      <= 1'b1;
          hit_link_r <= link_rd;
          found_r    <= kv_rd[31:0];
        end else begin
          prev_r <= cur_r;
          cur_r  <= link_rd;
        end
      end
      B_FIN: begin
        alloc_r            <= alloc_e;
        out_r.status       <= status_c;
        out_r.found_value  <= (item_r.op == chme_pkg::OP_GET && hit_r) ? found_r : '0;
        out_r.item_total   <= 11'(count_nxt);
      end
      B_LINK: ;
      default: ;
    endcase
  end

endmodule

/* rtl/chme_checker.sv */
// Port-level checker of the chained hash map engine and its bind.
`include "chained_hash_map_engine_assert.svh"

module chme_checker #(
  parameter int ENTRIES = 1024
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input chme_pkg::out_item_t out_result
);

  `CHME_ASSERT_RESET(a_reset_quiet, !rst_n, !out_valid)
  `CHME_ASSERT_NEXT(a_result_gap, out_valid, !out_valid)
  `CHME_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CHME_ASSERT_NOW(a_found_zero, out_valid && out_result.status != chme_pkg::ST_OK,
                   out_result.found_value == 32'd0)
  `CHME_ASSERT_NOW(a_total_bound, out_valid, out_result.item_total <= 11'(ENTRIES))

endmodule

bind chained_hash_map_engine chme_checker #(.ENTRIES(ENTRIES)) u_chme_checker (.*);
